@@ sv/ddo_pkg.sv @@
// Shared types, codes, constants and tables of the differential-drive odometry unit.
package ddo_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WB   = 2'd1;

    localparam logic [23:0] DIST_RESET = 24'd128474;
    localparam logic [19:0] WB_RESET   = 20'd16974;

    // Fixed-point constants: 2^31/pi, CORDIC start value (Q30)
    localparam logic signed [31:0] RAD_TO_ANG32 = 32'sd683565276;
    localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    // Divider geometry: magnitude of dividend, divisor, signed quotient and remainder
    localparam int DIV_NW = 52;
    localparam int DIV_DW = 36;
    localparam int DIV_QW = 53;
    localparam int DIV_RW = 37;

    typedef struct packed {
        logic signed [15:0] left_increments;
        logic signed [15:0] right_increments;
        logic        [15:0] interval_ms;
    } t_item;

    typedef struct packed {
        logic signed [31:0] right_speed;
        logic signed [31:0] left_speed;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
        logic signed [15:0] heading;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE, S_M_DL, S_M_DR, S_M_WD,
        S_DV_VR, S_W_VR, S_DV_VL, S_W_VL, S_DV_AN, S_W_AN,
        S_DV_QM, S_W_QM, S_M_MR, S_DV_T, S_W_T,
        S_M_QLO, S_M_QHI, S_D32,
        S_C_INIT, S_C_RUN, S_C_FIN,
        S_M_XLO, S_M_XHI, S_M_YLO, S_M_YHI, S_ACC_Y, S_POSE
    } t_state;

    typedef enum logic [4:0] {
        CMD_IDLE, CMD_LOAD, CMD_M_DL, CMD_M_DR, CMD_M_WD,
        CMD_DV_VR, CMD_ST_VR, CMD_DV_VL, CMD_ST_VL, CMD_DV_AN, CMD_ST_AN,
        CMD_DV_QM, CMD_ST_QM, CMD_M_MR, CMD_DV_T, CMD_ST_T,
        CMD_M_QLO, CMD_M_QHI, CMD_D32,
        CMD_C_INIT, CMD_C_RUN, CMD_C_FIN,
        CMD_M_XLO, CMD_M_XHI, CMD_M_YLO, CMD_M_YHI, CMD_ACC_Y, CMD_POSE
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctrl;

    typedef struct packed {
        logic div_busy;
        logic cordic_last;
        logic out_free;
    } t_stat;

    // Arctangent of 2^-i, 2^32 = one turn
    function automatic logic [31:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [DIV_QW-1:0] v);
        logic signed [31:0] r;
        if (v > 53'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -53'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ sv/ddo_in_if.sv @@
// Input channel carrying one set of encoder increments and the interval.
interface ddo_in_if;
    logic           valid;
    logic           ready;
    ddo_pkg::t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/ddo_out_if.sv @@
// Output channel carrying speeds and the updated pose.
interface ddo_out_if;
    logic             valid;
    logic             ready;
    ddo_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/diff_drive_odometry_unit.sv @@
// Top level of the differential-drive odometry unit.
//
// Each input beat carries signed left and right encoder increments and the elapsed interval
// in milliseconds (zero counts as one). The unit answers with exactly one output beat: both
// wheel speeds, their mean and the turn rate in Q15.16 (saturated to 32 bits), and the pose
// after midpoint integration: x and y in Q15.16 metres and the heading as a 16-bit binary
// angle where 32768 is pi, so it wraps exactly. The sequencer loads the output register as
// it returns to idle, so the next input beat can be taken at the same edge as the earliest
// output beat, and a new input beat is taken only once the previous update is through. The
// pace is set by the shared radix-2 divider, which works through five quotients in turn
// (both wheel speeds, turn rate, heading change quotient and its remainder term), followed
// by the iterative CORDIC at one step per cycle. The result sits in an output register, so
// the next input beat is accepted while the previous result still waits; a finished update
// holds only while that register is full.
// Write distance_per_increment (index 0) and wheel_base (index 1) through the write port
// only while no update is in flight; a write to any other index is dropped.
module diff_drive_odometry_unit #(
    parameter int ANGLE_BITS    = 16,
    parameter int POSITION_BITS = 32,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ddo_in_if.sink                         i_item,
    ddo_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ddo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    ddo_pkg::t_ctrl ctrl;
    ddo_pkg::t_stat stat;
    logic           in_ready;

    // Sequencer: one item at a time, advance on divider, CORDIC and output register status
    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    // Datapath: holds configuration, pose and the output register
    ddo_dp #(
        .ANGLE_BITS    (ANGLE_BITS),
        .POSITION_BITS (POSITION_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_item         (i_item.payload),
        .o_result       (o_result.payload),
        .o_result_valid (o_result.valid),
        .i_result_ready (o_result.ready),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    assign i_item.ready = in_ready;

endmodule

@@ sv/ddo_div.sv @@
// Radix-2 restoring signed divider, quotient and remainder truncated toward zero.
module ddo_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ddo_pkg::DIV_NW-1:0] i_num,
    input  logic        [ddo_pkg::DIV_DW-1:0] i_den,
    output logic                              o_busy,
    output logic signed [ddo_pkg::DIV_QW-1:0] o_quo,
    output logic signed [ddo_pkg::DIV_RW-1:0] o_rem
);
    localparam int NW = ddo_pkg::DIV_NW;
    localparam int DW = ddo_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_mag;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;

    logic [NW-1:0] num_u;
    logic [NW-1:0] mag;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          fits;

    assign num_u   = i_num;
    assign mag     = num_u[NW-1] ? (NW'(0) - num_u) : num_u;
    assign rem_sh  = {r_rem, r_mag[NW-1]};
    assign fits    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Shift the dividend out and the quotient bits in through the same register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            r_mag <= {r_mag[NW-2:0], fits};
            r_rem <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    assign o_rem  = r_neg ? -$signed({1'b0, r_rem}) : $signed({1'b0, r_rem});

endmodule

@@ sv/ddo_ctrl.sv @@
// Sequencer that steps the datapath through one odometry update.
module ddo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ddo_pkg::t_stat i_stat,
    output ddo_pkg::t_ctrl o_ctrl
);
    ddo_pkg::t_state r_state;
    ddo_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddo_pkg::S_IDLE:   if (i_in_valid) n_state = ddo_pkg::S_M_DL;
            ddo_pkg::S_M_DL:   n_state = ddo_pkg::S_M_DR;
            ddo_pkg::S_M_DR:   n_state = ddo_pkg::S_M_WD;
            ddo_pkg::S_M_WD:   n_state = ddo_pkg::S_DV_VR;
            ddo_pkg::S_DV_VR:  n_state = ddo_pkg::S_W_VR;
            ddo_pkg::S_W_VR:   if (!i_stat.div_busy) n_state = ddo_pkg::S_DV_VL;
            ddo_pkg::S_DV_VL:  n_state = ddo_pkg::S_W_VL;
            ddo_pkg::S_W_VL:   if (!i_stat.div_busy) n_state = ddo_pkg::S_DV_AN;
            ddo_pkg::S_DV_AN:  n_state = ddo_pkg::S_W_AN;
            ddo_pkg::S_W_AN:   if (!i_stat.div_busy) n_state = ddo_pkg::S_DV_QM;
            ddo_pkg::S_DV_QM:  n_state = ddo_pkg::S_W_QM;
            ddo_pkg::S_W_QM:   if (!i_stat.div_busy) n_state = ddo_pkg::S_M_MR;
            ddo_pkg::S_M_MR:   n_state = ddo_pkg::S_DV_T;
            ddo_pkg::S_DV_T:   n_state = ddo_pkg::S_W_T;
            ddo_pkg::S_W_T:    if (!i_stat.div_busy) n_state = ddo_pkg::S_M_QLO;
            ddo_pkg::S_M_QLO:  n_state = ddo_pkg::S_M_QHI;
            ddo_pkg::S_M_QHI:  n_state = ddo_pkg::S_D32;
            ddo_pkg::S_D32:    n_state = ddo_pkg::S_C_INIT;
            ddo_pkg::S_C_INIT: n_state = ddo_pkg::S_C_RUN;
            ddo_pkg::S_C_RUN:  if (i_stat.cordic_last) n_state = ddo_pkg::S_C_FIN;
            ddo_pkg::S_C_FIN:  n_state = ddo_pkg::S_M_XLO;
            ddo_pkg::S_M_XLO:  n_state = ddo_pkg::S_M_XHI;
            ddo_pkg::S_M_XHI:  n_state = ddo_pkg::S_M_YLO;
            ddo_pkg::S_M_YLO:  n_state = ddo_pkg::S_M_YHI;
            ddo_pkg::S_M_YHI:  n_state = ddo_pkg::S_ACC_Y;
            ddo_pkg::S_ACC_Y:  n_state = ddo_pkg::S_POSE;
            ddo_pkg::S_POSE:   if (i_stat.out_free) n_state = ddo_pkg::S_IDLE;
            default:           n_state = ddo_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_ctrl.cmd = ddo_pkg::CMD_IDLE;
        unique case (r_state)
            ddo_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctrl.cmd = ddo_pkg::CMD_LOAD;
            end
            ddo_pkg::S_M_DL:   o_ctrl.cmd = ddo_pkg::CMD_M_DL;
            ddo_pkg::S_M_DR:   o_ctrl.cmd = ddo_pkg::CMD_M_DR;
            ddo_pkg::S_M_WD:   o_ctrl.cmd = ddo_pkg::CMD_M_WD;
            ddo_pkg::S_DV_VR:  o_ctrl.cmd = ddo_pkg::CMD_DV_VR;
            ddo_pkg::S_W_VR:   if (!i_stat.div_busy) o_ctrl.cmd = ddo_pkg::CMD_ST_VR;
            ddo_pkg::S_DV_VL:  o_ctrl.cmd = ddo_pkg::CMD_DV_VL;
            ddo_pkg::S_W_VL:   if (!i_stat.div_busy) o_ctrl.cmd = ddo_pkg::CMD_ST_VL;
            ddo_pkg::S_DV_AN:  o_ctrl.cmd = ddo_pkg::CMD_DV_AN;
            ddo_pkg::S_W_AN:   if (!i_stat.div_busy) o_ctrl.cmd = ddo_pkg::CMD_ST_AN;
            ddo_pkg::S_DV_QM:  o_ctrl.cmd = ddo_pkg::CMD_DV_QM;
            ddo_pkg::S_W_QM:   if (!i_stat.div_busy) o_ctrl.cmd = ddo_pkg::CMD_ST_QM;
            ddo_pkg::S_M_MR:   o_ctrl.cmd = ddo_pkg::CMD_M_MR;
            ddo_pkg::S_DV_T:   o_ctrl.cmd = ddo_pkg::CMD_DV_T;
            ddo_pkg::S_W_T:    if (!i_stat.div_busy) o_ctrl.cmd = ddo_pkg::CMD_ST_T;
            ddo_pkg::S_M_QLO:  o_ctrl.cmd = ddo_pkg::CMD_M_QLO;
            ddo_pkg::S_M_QHI:  o_ctrl.cmd = ddo_pkg::CMD_M_QHI;
            ddo_pkg::S_D32:    o_ctrl.cmd = ddo_pkg::CMD_D32;
            ddo_pkg::S_C_INIT: o_ctrl.cmd = ddo_pkg::CMD_C_INIT;
            ddo_pkg::S_C_RUN:  o_ctrl.cmd = ddo_pkg::CMD_C_RUN;
            ddo_pkg::S_C_FIN:  o_ctrl.cmd = ddo_pkg::CMD_C_FIN;
            ddo_pkg::S_M_XLO:  o_ctrl.cmd = ddo_pkg::CMD_M_XLO;
            ddo_pkg::S_M_XHI:  o_ctrl.cmd = ddo_pkg::CMD_M_XHI;
            ddo_pkg::S_M_YLO:  o_ctrl.cmd = ddo_pkg::CMD_M_YLO;
            ddo_pkg::S_M_YHI:  o_ctrl.cmd = ddo_pkg::CMD_M_YHI;
            ddo_pkg::S_ACC_Y:  o_ctrl.cmd = ddo_pkg::CMD_ACC_Y;
            ddo_pkg::S_POSE:   if (i_stat.out_free) o_ctrl.cmd = ddo_pkg::CMD_POSE;
            default:           o_ctrl.cmd = ddo_pkg::CMD_IDLE;
        endcase
    end

endmodule

@@ sv/ddo_dp.sv @@
// Datapath: configuration, shared multiplier, divider, CORDIC and pose registers.
module ddo_dp #(
    parameter int ANGLE_BITS    = 16,
    parameter int POSITION_BITS = 32,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ddo_pkg::t_ctrl                      i_ctrl,
    output ddo_pkg::t_stat                      o_stat,
    input  ddo_pkg::t_item                      i_item,
    output ddo_pkg::t_result                    o_result,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    input  logic                                i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int ASH    = 32 - ANGLE_BITS;
    localparam int NSTEPS = (CORDIC_STEPS > ddo_pkg::ATAN_ENTRIES) ?
                            ddo_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int P      = POSITION_BITS;
    localparam int SW     = ddo_pkg::ATAN_IDX_W;
    localparam logic signed [63:0] ROUND   = 64'sh0000_0040_0000_0000;
    localparam logic signed [33:0] QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] HALFT   = 34'sd2147483648;
    localparam logic [31:0]        HLSB    = 32'd1 << (ASH - 1);

    function automatic logic signed [51:0] times_k(input logic signed [51:0] v);
        return (v <<< 10) - (v <<< 4) - (v <<< 3);
    endfunction

    // Configuration
    logic [23:0] r_dist;
    logic [19:0] r_wb;
    logic [19:0] wb_eff;

    // Working registers
    logic signed [15:0] r_li, r_ri;
    logic        [15:0] r_dt;
    logic signed [63:0] r_prod;
    logic signed [39:0] r_dl, r_dr;
    logic signed [40:0] r_num, r_ds2;
    logic        [35:0] r_wbdt;
    logic signed [31:0] r_vr, r_vl, r_ang;
    logic signed [40:0] r_q;
    logic signed [20:0] r_m;
    logic        [31:0] r_term;
    logic        [47:0] r_qr;
    logic        [31:0] r_d32;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_flip;
    logic      [SW-1:0] r_step;
    logic signed [25:0] r_c, r_s;
    logic signed [63:0] r_acc;
    logic       [P-1:0] r_pose_x, r_pose_y;
    logic [ANGLE_BITS-1:0] r_heading;
    ddo_pkg::t_result   r_result;
    logic               r_result_valid;

    ddo_pkg::t_cmd cmd;
    assign cmd    = i_ctrl.cmd;
    assign wb_eff = (r_wb == '0) ? 20'd1 : r_wb;

    // Shared multiplier operands
    logic signed [31:0] mul_a, mul_b;
    logic signed [47:0] q48;
    logic signed [19:0] ds2_hi;
    assign q48    = 48'(r_q);
    assign ds2_hi = r_ds2[40:21];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            ddo_pkg::CMD_M_DL: begin
                mul_a = 32'(r_li);
                mul_b = $signed({8'b0, r_dist});
            end
            ddo_pkg::CMD_M_DR: begin
                mul_a = 32'(r_ri);
                mul_b = $signed({8'b0, r_dist});
            end
            ddo_pkg::CMD_M_WD: begin
                mul_a = $signed({12'b0, wb_eff});
                mul_b = $signed({16'b0, r_dt});
            end
            ddo_pkg::CMD_M_MR: begin
                mul_a = 32'(r_m);
                mul_b = ddo_pkg::RAD_TO_ANG32;
            end
            ddo_pkg::CMD_M_QLO: begin
                mul_a = $signed({8'b0, q48[23:0]});
                mul_b = ddo_pkg::RAD_TO_ANG32;
            end
            ddo_pkg::CMD_M_QHI: begin
                mul_a = $signed({8'b0, q48[47:24]});
                mul_b = ddo_pkg::RAD_TO_ANG32;
            end
            ddo_pkg::CMD_M_XLO: begin
                mul_a = $signed({11'b0, r_ds2[20:0]});
                mul_b = 32'(r_c);
            end
            ddo_pkg::CMD_M_XHI: begin
                mul_a = 32'(ds2_hi);
                mul_b = 32'(r_c);
            end
            ddo_pkg::CMD_M_YLO: begin
                mul_a = $signed({11'b0, r_ds2[20:0]});
                mul_b = 32'(r_s);
            end
            ddo_pkg::CMD_M_YHI: begin
                mul_a = 32'(ds2_hi);
                mul_b = 32'(r_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operands
    logic                                div_start, div_busy;
    logic signed [ddo_pkg::DIV_NW-1:0]   div_num;
    logic        [ddo_pkg::DIV_DW-1:0]   div_den;
    logic signed [ddo_pkg::DIV_QW-1:0]   div_quo;
    logic signed [ddo_pkg::DIV_RW-1:0]   div_rem;

    always_comb begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        case (cmd)
            ddo_pkg::CMD_DV_VR: begin
                div_num = times_k(52'(r_dr));
                div_den = {4'b0, r_dt, 16'b0};
            end
            ddo_pkg::CMD_DV_VL: begin
                div_num = times_k(52'(r_dl));
                div_den = {4'b0, r_dt, 16'b0};
            end
            ddo_pkg::CMD_DV_AN: begin
                div_num = times_k(52'(r_num));
                div_den = r_wbdt;
            end
            ddo_pkg::CMD_DV_QM: begin
                div_num = 52'(r_num);
                div_den = {16'b0, wb_eff};
            end
            ddo_pkg::CMD_DV_T: begin
                div_num = r_prod[51:0];
                div_den = {wb_eff, 16'b0};
            end
            default: div_start = 1'b0;
        endcase
    end

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Heading change and mid-step angle
    logic        [47:0] sum48;
    logic signed [31:0] d32s, half;
    logic        [31:0] mid;
    logic signed [33:0] z0;
    assign sum48 = r_qr + {r_prod[23:0], 24'b0};
    assign d32s  = r_d32;
    assign half  = d32s >>> 1;
    assign mid   = {r_heading, {ASH{1'b0}}} + half;
    assign z0    = 34'($signed(mid));

    // CORDIC step
    logic signed [33:0] xs, ys, at, xf, yf;
    assign xs = r_cx >>> r_step;
    assign ys = r_cy >>> r_step;
    assign at = $signed({2'b0, ddo_pkg::atan_angle(r_step)});
    assign xf = r_flip ? -r_cx : r_cx;
    assign yf = r_flip ? -r_cy : r_cy;

    // Pose update
    logic signed [63:0] acc_sh;
    logic       [P-1:0] dmove, n_pose_y;
    logic        [31:0] hinc;
    logic [ANGLE_BITS-1:0] n_heading;
    logic        [31:0] theta_new;
    logic signed [32:0] vsum, vsum_r;
    logic signed [P-1:0] px_s, py_s;
    logic signed [63:0] px64, py64;
    assign acc_sh    = r_acc >>> 39;
    assign dmove     = acc_sh[P-1:0];
    assign n_pose_y  = r_pose_y + dmove;
    assign hinc      = (r_d32 + HLSB) >> ASH;
    assign n_heading = r_heading + hinc[ANGLE_BITS-1:0];
    assign theta_new = {n_heading, {ASH{1'b0}}};
    assign vsum      = 33'(r_vr) + 33'(r_vl);
    assign vsum_r    = vsum + $signed({32'b0, vsum[32]});
    assign px_s      = r_pose_x;
    assign py_s      = n_pose_y;
    assign px64      = 64'(px_s);
    assign py64      = 64'(py_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= ddo_pkg::DIST_RESET;
            r_wb   <= ddo_pkg::WB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ddo_pkg::REG_DIST: r_dist <= i_cfg_data;
                ddo_pkg::REG_WB:   r_wb   <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x       <= '0;
            r_pose_y       <= '0;
            r_heading      <= '0;
            r_result_valid <= 1'b0;
        end else begin
            if (cmd == ddo_pkg::CMD_M_YHI) begin
                r_pose_x <= r_pose_x + dmove;
            end
            if (cmd == ddo_pkg::CMD_POSE) begin
                r_pose_y       <= n_pose_y;
                r_heading      <= n_heading;
                r_result_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_result_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (cmd)
            ddo_pkg::CMD_LOAD: begin
                r_li <= i_item.left_increments;
                r_ri <= i_item.right_increments;
                r_dt <= (i_item.interval_ms == '0) ? 16'd1 : i_item.interval_ms;
            end
            ddo_pkg::CMD_M_DR: r_dl <= r_prod[39:0];
            ddo_pkg::CMD_M_WD: r_dr <= r_prod[39:0];
            ddo_pkg::CMD_DV_VR: begin
                r_wbdt <= r_prod[35:0];
                r_num  <= 41'(r_dr) - 41'(r_dl);
            end
            ddo_pkg::CMD_ST_VR: r_vr  <= ddo_pkg::sat32(div_quo);
            ddo_pkg::CMD_ST_VL: r_vl  <= ddo_pkg::sat32(div_quo);
            ddo_pkg::CMD_ST_AN: r_ang <= ddo_pkg::sat32(div_quo);
            ddo_pkg::CMD_ST_QM: begin
                r_q <= div_quo[40:0];
                r_m <= div_rem[20:0];
            end
            ddo_pkg::CMD_ST_T:  r_term <= div_quo[31:0];
            ddo_pkg::CMD_M_QHI: r_qr   <= r_prod[47:0];
            ddo_pkg::CMD_D32:   r_d32  <= sum48[47:16] + r_term;
            ddo_pkg::CMD_C_INIT: begin
                // Fold angles beyond a quarter turn by half a turn
                if (z0 > QUARTER) begin
                    r_cz   <= z0 - HALFT;
                    r_flip <= 1'b1;
                end else if (z0 < -QUARTER) begin
                    r_cz   <= z0 + HALFT;
                    r_flip <= 1'b1;
                end else begin
                    r_cz   <= z0;
                    r_flip <= 1'b0;
                end
                r_cx   <= ddo_pkg::CORDIC_K;
                r_cy   <= '0;
                r_step <= '0;
                r_ds2  <= 41'(r_dl) + 41'(r_dr);
            end
            ddo_pkg::CMD_C_RUN: begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - at;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + at;
                end
                r_step <= r_step + 1'b1;
            end
            ddo_pkg::CMD_C_FIN: begin
                r_c <= 26'(xf >>> 8);
                r_s <= 26'(yf >>> 8);
            end
            ddo_pkg::CMD_M_XHI: r_acc <= r_prod + ROUND;
            ddo_pkg::CMD_M_YLO: r_acc <= r_acc + (r_prod <<< 21);
            ddo_pkg::CMD_M_YHI: r_acc <= r_prod + ROUND;
            ddo_pkg::CMD_ACC_Y: r_acc <= r_acc + (r_prod <<< 21);
            ddo_pkg::CMD_POSE: begin
                r_result.right_speed   <= r_vr;
                r_result.left_speed    <= r_vl;
                r_result.linear_speed  <= vsum_r[32:1];
                r_result.angular_speed <= r_ang;
                r_result.x_position    <= px64[31:0];
                r_result.y_position    <= py64[31:0];
                r_result.heading       <= theta_new[31:16];
            end
            default: ;
        endcase
    end

    assign o_stat.div_busy    = div_busy;
    assign o_stat.cordic_last = (r_step == SW'(NSTEPS - 1));
    assign o_stat.out_free    = !r_result_valid || i_result_ready;
    assign o_result           = r_result;
    assign o_result_valid     = r_result_valid;

endmodule

@@ bench/ddo_checker.sv @@
`timescale 1ns / 1ps
// Odometry predictor and result checker watching the input and output channels.
module ddo_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  ddo_pkg::t_item                 i_in_beat,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  ddo_pkg::t_result               i_out_beat,
    input  logic                           i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ddo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    localparam longint ANG_SCALE = 64'sd683565276;
    localparam longint START_K   = 64'sd652032874;

    logic [23:0] dist_reg;
    logic [19:0] base_reg;
    logic [31:0] track_x, track_y;
    logic [15:0] track_hdg;
    ddo_pkg::t_result pose_queue[$];

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_step(input int i);
        longint tbl[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                            64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};
        return tbl[i];
    endfunction

    task automatic advance_pose(input ddo_pkg::t_item it, output ddo_pkg::t_result r);
        longint li, ri, dt, d, wb, dl, dr, vr, vl, num, q, m, term2, half, c, s;
        longint z, cx, cy, xs, ys, ds2, dx, dy;
        logic [31:0] d32, mid;
        logic [63:0] qprod;
        bit flip;
        li = it.left_increments;
        ri = it.right_increments;
        dt = (it.interval_ms == 0) ? 1 : it.interval_ms;
        d = dist_reg;
        wb = (base_reg == 0) ? 1 : base_reg;
        dl = li * d;
        dr = ri * d;
        vr = clip32(dr * 1000 / (dt * 65536));
        vl = clip32(dl * 1000 / (dt * 65536));
        num = dr - dl;
        r.right_speed = vr[31:0];
        r.left_speed = vl[31:0];
        r.linear_speed = 32'((vr + vl) / 2);
        r.angular_speed = 32'(clip32(num * 1000 / (wb * dt)));
        q = num / wb;
        m = num % wb;
        term2 = (m * ANG_SCALE) / (wb * 65536);
        qprod = 64'(q) * 64'(ANG_SCALE);
        d32 = 32'((qprod >> 16) + 64'(term2));
        half = floor_shift(longint'($signed(d32)), 1);
        mid = {track_hdg, 16'h0} + 32'(half);
        // CORDIC rotation, folding beyond a quarter turn
        z = longint'($signed(mid));
        cx = START_K;
        cy = 0;
        flip = 0;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000; flip = 1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000; flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0) begin
                cx -= ys; cy += xs; z -= atan_step(i);
            end else begin
                cx += ys; cy -= xs; z += atan_step(i);
            end
        end
        if (flip) begin
            cx = -cx; cy = -cy;
        end
        c = cx >>> 8;
        s = cy >>> 8;
        ds2 = dl + dr;
        dx = (ds2 * c + (64'sd1 <<< 38)) >>> 39;
        dy = (ds2 * s + (64'sd1 <<< 38)) >>> 39;
        track_x += 32'(dx);
        track_y += 32'(dy);
        track_hdg += 16'((d32 + 32'h8000) >> 16);
        r.x_position = track_x;
        r.y_position = track_y;
        r.heading = track_hdg;
    endtask

    always @(posedge i_clk) begin
        ddo_pkg::t_result want, got;
        if (!i_rst_n) begin
            dist_reg <= ddo_pkg::DIST_RESET;
            base_reg <= ddo_pkg::WB_RESET;
            track_x = '0;
            track_y = '0;
            track_hdg = '0;
            pose_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ddo_pkg::REG_DIST) dist_reg <= i_cfg_data;
                else if (i_cfg_idx == ddo_pkg::REG_WB) base_reg <= i_cfg_data[19:0];
            end
            if (i_in_valid && i_in_ready) begin
                advance_pose(i_in_beat, want);
                pose_queue.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_beat;
                if (pose_queue.size() == 0) begin
                    $error("unexpected result beat %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pose_queue.pop_front();
                    if (got !== want) begin
                        if (got.right_speed !== want.right_speed)
                            $error("right_speed exp %0d got %0d", want.right_speed, got.right_speed);
                        if (got.left_speed !== want.left_speed)
                            $error("left_speed exp %0d got %0d", want.left_speed, got.left_speed);
                        if (got.linear_speed !== want.linear_speed)
                            $error("linear_speed exp %0d got %0d", want.linear_speed,
                                   got.linear_speed);
                        if (got.angular_speed !== want.angular_speed)
                            $error("angular_speed exp %0d got %0d", want.angular_speed,
                                   got.angular_speed);
                        if (got.x_position !== want.x_position)
                            $error("x_position exp %0d got %0d", want.x_position, got.x_position);
                        if (got.y_position !== want.y_position)
                            $error("y_position exp %0d got %0d", want.y_position, got.y_position);
                        if (got.heading !== want.heading)
                            $error("heading exp %0d got %0d", want.heading, got.heading);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= pose_queue.size();
    end
endmodule

@@ bench/tb_diff_drive_odometry_unit.sv @@
`timescale 1ns / 1ps
// Testbench top of the odometry unit: stimulus, register writes, stalls and verdict.
module tb_diff_drive_odometry_unit;

    // The random beats, together with the stall phases and gaps, stay well inside the
    // limit below.
    localparam int RANDOM_BEATS = 1700;
    localparam int DRAIN_CYCLES = 400;
    localparam logic [ddo_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ddo_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ddo_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    int   fail_count, pending;
    bit   hold_off = 1'b0;

    ddo_in_if  item_ch();
    ddo_out_if result_ch();

    always #4 i_clk = ~i_clk;

    diff_drive_odometry_unit i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch.sink),
        .o_result  (result_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    ddo_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (item_ch.valid),
        .i_in_ready  (item_ch.ready),
        .i_in_beat   (item_ch.payload),
        .i_out_valid (result_ch.valid),
        .i_out_ready (result_ch.ready),
        .i_out_beat  (result_ch.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
    end

    // Receiver: stall on its own pattern, and hold off entirely while asked to.
    always @(negedge i_clk) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (hold_off) result_ch.ready <= 1'b0;
        else result_ch.ready <= (pick < 70) || ($time / 20000) % 3 == 0;
    end

    // Offer one beat and hold it until taken; drop valid only when the burst ends.
    task automatic send_beat(input ddo_pkg::t_item it, input bit keep_valid);
        item_ch.valid <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!keep_valid) item_ch.valid <= 1'b0;
    endtask

    // Gap between bursts, wherever it falls in the update.
    task automatic pause_sender(input int gap);
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[ddo_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait until every result is in and the block is idle before touching registers.
    task automatic settle();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic ddo_pkg::t_item rand_item();
        ddo_pkg::t_item it;
        int pick;
        pick = $urandom_range(0, 9);
        it.left_increments = 16'($urandom);
        it.right_increments = 16'($urandom);
        it.interval_ms = 16'($urandom);
        // Mostly plausible motion, some full-range spins; the rest full-range noise
        if (pick < 6) begin
            it.left_increments = 16'($signed($urandom_range(0, 400)) - 200);
            it.right_increments = it.left_increments + 16'($signed($urandom_range(0, 60)) - 30);
            it.interval_ms = 16'($urandom_range(0, 20));
        end else if (pick < 8) begin
            it.right_increments = -it.left_increments;
        end
        return it;
    endfunction

    initial begin
        ddo_pkg::t_item it;
        int burst;
        int gap;
        int unsigned dists[5] = '{128474, 1, 16777215, 5000000, 40000};
        int unsigned bases[5] = '{16974, 1, 1048575, 3000, 65536};
        logic signed [15:0] extremes[5] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes at reset settings, zero interval, full interval, spins
        for (int k = 0; k < 20; k++) begin
            it.left_increments = extremes[k % 5];
            it.right_increments = extremes[(k / 5 + k) % 5];
            it.interval_ms = (k % 3 == 0) ? 16'd0 : (k % 3 == 1) ? 16'hFFFF : 16'd1;
            send_beat(it, k != 19);
        end
        settle();

        // Zero distance per increment, zero wheel base and an ignored index
        write_reg(ddo_pkg::REG_DIST, 0);
        write_reg(ddo_pkg::REG_WB, 0);
        write_reg(REG_SPARE, 24'hFFFFFF);
        for (int k = 0; k < 4; k++) begin
            it.left_increments = extremes[k];
            it.right_increments = extremes[4 - k];
            it.interval_ms = 16'(k);
            send_beat(it, k != 3);
        end
        settle();

        // Random phases, one register setting each
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(ddo_pkg::REG_DIST, dists[ph]);
            write_reg(ddo_pkg::REG_WB, bases[ph]);
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps offering beats
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    for (int k = 0; k < 8; k++) send_beat(rand_item(), k != 7);
                join
                @(negedge i_clk);
            end
            for (int n = 0; n < RANDOM_BEATS / 5;) begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
                for (int b = 0; b < burst && n < RANDOM_BEATS / 5; b++, n++)
                    send_beat(rand_item(),
                              (b != burst - 1 || gap == 0) && n != RANDOM_BEATS / 5 - 1);
                pause_sender(gap);
            end
            settle();
        end

        if (fail_count == 0) $display("tb_diff_drive_odometry_unit: done, clean");
        else $display("tb_diff_drive_odometry_unit: done, errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_diff_drive_odometry_unit: done, errors");
        $finish;
    end
endmodule

@@ diff_drive_odometry_unit.f @@
sv/ddo_pkg.sv
sv/ddo_in_if.sv
sv/ddo_out_if.sv
sv/ddo_div.sv
sv/ddo_ctrl.sv
sv/ddo_dp.sv
sv/diff_drive_odometry_unit.sv
bench/ddo_checker.sv
bench/tb_diff_drive_odometry_unit.sv
